>>> src/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned STS_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_END  = 3'd5
  } mode_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_DIVZERO   = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_UNDERFLOW = 3'd3,
    STS_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_EXEC,
    SEQ_ALU
  } seq_e;

  // request to the arithmetic unit
  typedef struct packed {
    logic  start;
    mode_e op;
  } alu_ctl_t;

endpackage

`default_nettype wire

>>> src/rse_stack.sv
// ----------------------------------------------------------------------------
// rse_stack
// Operand stack storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_stack #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [rse_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_a_i,
  input  wire logic [AW-1:0]             raddr_b_i,
  output      logic [rse_pkg::DATA_W-1:0] rdata_a_o,
  output      logic [rse_pkg::DATA_W-1:0] rdata_b_o
);
  import rse_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> src/rse_alu.sv
// ----------------------------------------------------------------------------
// rse_alu
// Shared arithmetic unit: add, subtract, multiply, signed
// divide (truncating) by a restoring loop, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_alu (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rse_pkg::alu_ctl_t          ctl_i,
  input  wire logic [rse_pkg::DATA_W-1:0] lhs_i,
  input  wire logic [rse_pkg::DATA_W-1:0] rhs_i,
  output      logic                       done_o,
  output      logic [rse_pkg::DATA_W-1:0] res_o
);
  import rse_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] div_q, div_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] res_q, res_d;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_diff;
  logic [DATA_W-1:0] quo_nx;
  logic [DATA_W-1:0] mag_l, mag_r;

  always_comb begin
    mag_l    = lhs_i[DATA_W-1] ? (DATA_W'(0) - lhs_i) : lhs_i;
    mag_r    = rhs_i[DATA_W-1] ? (DATA_W'(0) - rhs_i) : rhs_i;
    rem_sh   = {rem_q, quo_q[DATA_W-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    quo_nx   = {quo_q[DATA_W-2:0], ~rem_diff[DATA_W]};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    neg_d  = neg_q;
    res_d  = res_q;

    if (busy_q) begin
      rem_d = rem_diff[DATA_W] ? rem_sh[DATA_W-1:0] : rem_diff[DATA_W-1:0];
      quo_d = quo_nx;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (DATA_W'(0) - quo_nx) : quo_nx;
      end
    end else if (ctl_i.start) begin
      case (ctl_i.op)
        MODE_ADD: begin
          res_d  = lhs_i + rhs_i;
          done_d = 1'b1;
        end
        MODE_SUB: begin
          res_d  = lhs_i - rhs_i;
          done_d = 1'b1;
        end
        MODE_MUL: begin
          res_d  = lhs_i * rhs_i;
          done_d = 1'b1;
        end
        MODE_DIV: begin
          busy_d = 1'b1;
          cnt_d  = CNT_W'(DATA_W - 1);
          rem_d  = '0;
          quo_d  = mag_l;
          div_d  = mag_r;
          neg_d  = lhs_i[DATA_W-1] ^ rhs_i[DATA_W-1];
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> src/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix expression evaluator: tokens in, one result item per end token.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                    tuser
//  s_axis    in   [30:0] value, zero pad   [2:0] mode
//  m_axis    out  [31:0] result            [2:0] status
//
//  Each token passes the read and execute states; an add, subtract, multiply
//  or divide that passes its checks then waits in the ALU state, the divide
//  loop taking one quotient bit per cycle. Stack reads use a registered port.
//  Any token waits while a previous result item is still held unread.
//  Reset empties the stack and clears any pending error.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [30:0] value, [31] zero
  input  wire logic [2:0]  s_axis_tuser_i,   // [2:0] mode
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,   // [31:0] result
  output      logic [2:0]  m_axis_tuser_o    // [2:0] status
);
  import rse_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  seq_e              state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  status_e           err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  status_e           out_sts_q, out_sts_d;

  mode_e              mode_q;
  logic [VALUE_W-1:0] value_q;

  logic              in_acc;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [AW-1:0]     addr_top, addr_nxt;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd_top, rd_nxt;
  alu_ctl_t          alu_ctl;
  logic              alu_done;
  logic [DATA_W-1:0] alu_res;

  assign s_axis_tready_o = (state_q == SEQ_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign cnt_m1   = count_q - CW'(1);
  assign cnt_m2   = count_q - CW'(2);
  assign addr_top = cnt_m1[AW-1:0];
  assign addr_nxt = cnt_m2[AW-1:0];

  rse_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (addr_top),
    .raddr_b_i (addr_nxt),
    .rdata_a_o (rd_top),
    .rdata_b_o (rd_nxt)
  );

  rse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .lhs_i  (rd_nxt),
    .rhs_i  (rd_top),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    err_d         = err_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_data_d    = out_data_q;
    out_sts_d     = out_sts_q;
    we            = 1'b0;
    waddr         = addr_nxt;
    wdata         = alu_res;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = mode_q;

    case (state_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          state_d = SEQ_READ;
        end
      end
      SEQ_READ: begin
        state_d = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        state_d = SEQ_IDLE;
        if (mode_q == MODE_END) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_sts_d   = err_q;
          if (err_q == STS_OK) begin
            if (count_q == '0) begin
              out_sts_d = STS_EMPTY;
            end else begin
              out_data_d = rd_top;
            end
          end
          count_d = '0;
          err_d   = STS_OK;
        end else if (err_q == STS_OK) begin
          case (mode_q)
            MODE_PUSH: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                err_d = STS_OVERFLOW;
              end else begin
                we      = 1'b1;
                waddr   = count_q[AW-1:0];
                wdata   = {1'b0, value_q};
                count_d = count_q + CW'(1);
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
              if (count_q < CW'(2)) begin
                err_d = STS_UNDERFLOW;
              end else if (mode_q == MODE_DIV && rd_top == '0) begin
                err_d   = STS_DIVZERO;
                count_d = cnt_m2;
              end else begin
                alu_ctl.start = 1'b1;
                state_d       = SEQ_ALU;
              end
            end
            default: begin
              state_d = SEQ_IDLE;
            end
          endcase
        end
      end
      SEQ_ALU: begin
        if (alu_done) begin
          we      = 1'b1;
          count_d = cnt_m1;
          state_d = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      count_q     <= '0;
      err_q       <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_sts_q  <= out_sts_d;
    if (in_acc) begin
      mode_q  <= mode_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i[VALUE_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sts_q;

endmodule

`default_nettype wire

>>> tb/rpn_stack_evaluator_chk.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_chk
// Watches both stream channels of the postfix evaluator, keeps a shadow
// stack fed by every accepted token, queues the expected result item for
// each end token and compares returned result items against the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rpn_stack_evaluator_chk #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] value, [31] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] mode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [31:0] result
  input  logic [2:0]  m_axis_tuser_i,   // [2:0] status
  output int          mismatch_cnt_o,
  output int          pending_o
);
  import rse_pkg::*;

  typedef struct packed {
    logic [31:0] result;
    status_e     status;
  } eval_res_t;

  eval_res_t   expected_q[$];
  logic [31:0] shadow_stack [STACK_DEPTH];
  int unsigned shadow_cnt;
  status_e     shadow_err;
  int          mismatch_total;

  // signed quotient, truncated toward zero; most negative / -1 wraps
  function automatic logic [31:0] trunc_div(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] quo;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    quo   = mag_n / mag_d;
    return (num[31] ^ den[31]) ? -quo : quo;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  task automatic apply_token(input logic [2:0] mode, input logic [30:0] value);
    eval_res_t   res;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] r;
    if (mode == MODE_END) begin
      res.result = '0;
      res.status = shadow_err;
      if (shadow_err == STS_OK) begin
        if (shadow_cnt == 0) res.status = STS_EMPTY;
        else res.result = shadow_stack[shadow_cnt-1];
      end
      expected_q.push_back(res);
      shadow_cnt = 0;
      shadow_err = STS_OK;
    end else if (mode <= MODE_DIV && shadow_err == STS_OK) begin
      if (mode == MODE_PUSH) begin
        if (shadow_cnt >= STACK_DEPTH) begin
          shadow_err = STS_OVERFLOW;
        end else begin
          shadow_stack[shadow_cnt] = {1'b0, value};
          shadow_cnt++;
        end
      end else if (shadow_cnt < 2) begin
        shadow_err = STS_UNDERFLOW;
      end else begin
        rhs = shadow_stack[shadow_cnt-1];
        lhs = shadow_stack[shadow_cnt-2];
        shadow_cnt -= 2;
        r = '0;
        case (mode)
          MODE_ADD: r = lhs + rhs;
          MODE_SUB: r = lhs - rhs;
          MODE_MUL: r = lhs * rhs;
          default: begin
            if (rhs == '0) shadow_err = STS_DIVZERO;
            else r = trunc_div(lhs, rhs);
          end
        endcase
        // operands stay popped on divide by zero
        if (shadow_err == STS_OK) begin
          shadow_stack[shadow_cnt] = r;
          shadow_cnt++;
        end
      end
    end
    // modes 6 and 7, and any token while an error is held, change nothing
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eval_res_t exp_res;
    if (!rst_ni) begin
      shadow_cnt = 0;
      shadow_err = STS_OK;
      expected_q.delete();
    end else begin
      // results first: an item accepted now cannot stem from a token at this edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result item: result %0d status %0d",
                                    $signed(m_axis_tdata_i), m_axis_tuser_i));
        end else begin
          exp_res = expected_q.pop_front();
          if (m_axis_tdata_i !== exp_res.result) begin
            report_mismatch($sformatf("result field: expected %0d, got %0d",
                                      $signed(exp_res.result), $signed(m_axis_tdata_i)));
          end
          if (m_axis_tuser_i !== exp_res.status) begin
            report_mismatch($sformatf("status field: expected %0d, got %0d",
                                      exp_res.status, m_axis_tuser_i));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_token(s_axis_tuser_i, s_axis_tdata_i[30:0]);
      end
    end
    mismatch_cnt_o <= mismatch_total;
    pending_o      <= expected_q.size();
  end

endmodule

>>> tb/rpn_stack_evaluator_tb.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_tb
// Feeds token streams to the postfix evaluator: a directed set of corner
// expressions, then random expressions, mostly well formed, under three
// idling patterns and one long output stall. Checking is in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rpn_stack_evaluator_tb;
  import rse_pkg::*;

  localparam int unsigned STACK_DEPTH = 32;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  int          mismatch_cnt;
  int          pending_cnt;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          token_cnt;
  int          hold_seq;
  int          hold_len;

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  rpn_stack_evaluator_chk #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rpn_stack_evaluator_tb failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off each time one is requested
  initial begin
    int hold_seen;
    hold_seen = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        m_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_token(input logic [2:0] mode, input logic [30:0] value);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, value};
    do @(posedge clk); while (!s_tready);
    token_cnt++;
  endtask

  function automatic logic [30:0] rand_operand();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 31'd1;
      2:       return 31'h7FFF_FFFF;
      3:       return 31'($urandom_range(0, 15));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_op();
    send_token(3'($urandom_range(MODE_ADD, MODE_DIV)), 31'($urandom));
  endtask

  task automatic send_push();
    send_token(MODE_PUSH, rand_operand());
  endtask

  task automatic random_expression();
    int kind;
    int pushes_left;
    int depth;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise, every mode including the meaningless ones, not always closed
      repeat ($urandom_range(1, 8)) send_token(3'($urandom_range(0, 7)), 31'($urandom));
      if ($urandom_range(1)) send_token(MODE_END, 31'($urandom));
    end else if (kind < 12) begin
      // run the stack up to, and sometimes past, its depth
      repeat (STACK_DEPTH - 2 + $urandom_range(0, 4)) send_push();
      repeat ($urandom_range(0, 3)) send_op();
      send_token(MODE_END, 31'($urandom));
    end else if (kind < 18) begin
      // too few operands for the operator
      repeat ($urandom_range(0, 1)) send_push();
      send_op();
      repeat ($urandom_range(0, 3)) send_push();
      send_token(MODE_END, 31'($urandom));
    end else begin
      pushes_left = $urandom_range(1, 12);
      depth = 0;
      while (pushes_left > 0 || depth > 1) begin
        if (pushes_left > 0 && (depth < 2 || $urandom_range(1))) begin
          send_push();
          pushes_left--;
          depth++;
        end else begin
          send_op();
          depth--;
        end
      end
      send_token(MODE_END, 31'($urandom));
    end
  endtask

  initial begin
    int phase;
    int target;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    hold_seq      = 0;
    hold_len      = 0;
    token_cnt     = 0;
    src_idle_pct  = 20;
    sink_idle_pct = 75;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // end on an empty stack, meaningless modes ignored
    send_token(3'd6, 31'h7FFF_FFFF);
    send_token(3'd7, 31'h0);
    send_token(MODE_END, 31'h0);
    // add wraps to the most negative value, which divided by -1 stays put
    send_token(MODE_PUSH, 31'h7FFF_FFFF);
    send_token(MODE_PUSH, 31'd1);
    send_token(MODE_ADD, 31'h0);
    send_token(MODE_PUSH, 31'd0);
    send_token(MODE_PUSH, 31'd1);
    send_token(MODE_SUB, 31'h7FFF_FFFF);
    send_token(MODE_DIV, 31'h0);
    send_token(MODE_END, 31'h0);
    // divide by zero, later tokens ignored
    send_token(MODE_PUSH, 31'd5);
    send_token(MODE_PUSH, 31'd0);
    send_token(MODE_DIV, 31'h0);
    send_token(MODE_PUSH, 31'd3);
    send_token(MODE_END, 31'h0);
    // underflow
    send_token(MODE_PUSH, 31'd7);
    send_token(MODE_MUL, 31'h0);
    send_token(MODE_END, 31'h0);
    // 7 / -2 truncates to -3, then times 3
    send_token(MODE_PUSH, 31'd7);
    send_token(MODE_PUSH, 31'd0);
    send_token(MODE_PUSH, 31'd2);
    send_token(MODE_SUB, 31'h0);
    send_token(MODE_DIV, 31'h0);
    send_token(MODE_PUSH, 31'd3);
    send_token(MODE_MUL, 31'h0);
    send_token(MODE_END, 31'h0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 20;
          sink_idle_pct = 75;
        end
        1: begin
          src_idle_pct  = 75;
          sink_idle_pct = 20;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          // long output stall while short expressions keep coming
          @(posedge clk);
          hold_len = 400;
          hold_seq++;
          repeat (12) begin
            send_push();
            send_push();
            send_op();
            send_token(MODE_END, 31'($urandom));
          end
        end
      endcase
      target = token_cnt + 360;
      while (token_cnt < target) random_expression();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("rpn_stack_evaluator_tb passed");
    end else begin
      $display("rpn_stack_evaluator_tb failed");
    end
    $finish;
  end

endmodule
